FILE: src/wcs_pkg.sv
package wcs_pkg;

   localparam int TIME_W     = 32;
   localparam int DUR_W      = 24;
   localparam int TEMP_W     = 16;
   localparam int SEC_W      = 15;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int LVL_W      = 11;
   localparam int HYST_W     = 9;

   // signed width used for all temperature compares
   localparam int CMP_W = TEMP_W + 2;

   localparam int READY_HYST_DECI = 10;

   // ceil(d / 1000) = ((d + 999) >> 3) * ceil(2^29 / 125) >> 29, exact for d < 2^24
   localparam int RND_W      = DUR_W + 1;
   localparam int DIV_M_W    = RND_W - 3;
   localparam int RECIP_W    = 23;
   localparam int RECIP_SH   = 29;
   localparam int PROD_W     = DIV_M_W + RECIP_W;
   localparam logic [9:0]         ROUND_UP  = 10'd999;
   localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_STANDBY = 3'd0;
   localparam mode_type MODE_FILL    = 3'd1;
   localparam mode_type MODE_HEAT    = 3'd2;
   localparam mode_type MODE_READY   = 3'd3;
   localparam mode_type MODE_WASH    = 3'd4;
   localparam mode_type MODE_WAIT    = 3'd5;
   localparam mode_type MODE_RINSE   = 3'd6;
   localparam mode_type MODE_FINISH  = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_READY_TEMP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_SETPT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_HYST    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ON       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OFF      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WASH_MS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_MS      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RINSE_MS     = 3'd7;

   localparam logic [LVL_W-1:0]  RST_READY_TEMP = 11'd550;
   localparam logic [LVL_W-1:0]  RST_HEAT_SETPT = 11'd650;
   localparam logic [HYST_W-1:0] RST_HEAT_HYST  = 9'd20;
   localparam logic [DUR_W-1:0]  RST_MIN_ON     = 24'd10000;
   localparam logic [DUR_W-1:0]  RST_MIN_OFF    = 24'd10000;
   localparam logic [DUR_W-1:0]  RST_WASH_MS    = 24'd600000;
   localparam logic [DUR_W-1:0]  RST_WAIT_MS    = 24'd60000;
   localparam logic [DUR_W-1:0]  RST_RINSE_MS   = 24'd300000;

   typedef struct packed {
      logic                     power_pressed;
      logic                     tank_full;
      logic                     boiler_full;
      logic                     door_closed;
      logic                     temp_valid;
      logic signed [TEMP_W-1:0] temperature;
      logic [TIME_W-1:0]        now_ms;
   } wcs_req_type;

   typedef struct packed {
      logic             tank_valve;
      logic             boiler_valve;
      logic             heater;
      logic             wash_pump;
      logic             rinse_pump;
      mode_type         mode;
      logic             water_ready;
      logic [SEC_W-1:0] remaining_sec;
   } wcs_rsp_type;

endpackage

FILE: src/wcs_if.sv
interface wcs_req_if
   import wcs_pkg::*;
();
   logic        valid;
   logic        ready;
   wcs_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wcs_rsp_if
   import wcs_pkg::*;
();
   logic        valid;
   logic        ready;
   wcs_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/wash_cycle_sequencer_with_heater.sv
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    one control tick: switches, temperature, now_ms
// rsp_chan  out  valid/ready    valves, pumps, heater, mode, water_ready, remaining_sec
// csr_*     in   csr_we         register index and write data, no read-back
//
// Three register stages: input, sequencer/heater state update, output.
// One request per cycle while rsp_chan is ready; rsp valid is the output stage valid.
// Mode, heater and readiness state advance as a request leaves the input stage.
// The remaining-seconds divide is a reciprocal multiply in the last stage.
// Synchronous reset restores the register defaults and standby mode.
// A stalled rsp_chan backs up stage by stage; req_chan.ready drops only when all are full.
module wash_cycle_sequencer_with_heater
   import wcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   wcs_req_if.sink               req_chan,
   wcs_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [LVL_W-1:0]  ready_temp_ff;
   logic [LVL_W-1:0]  heat_setpoint_ff;
   logic [HYST_W-1:0] heat_hysteresis_ff;
   logic [DUR_W-1:0]  heater_min_on_ff;
   logic [DUR_W-1:0]  heater_min_off_ff;
   logic [DUR_W-1:0]  wash_ms_ff;
   logic [DUR_W-1:0]  wait_ms_ff;
   logic [DUR_W-1:0]  rinse_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_temp_ff      <= RST_READY_TEMP;
         heat_setpoint_ff   <= RST_HEAT_SETPT;
         heat_hysteresis_ff <= RST_HEAT_HYST;
         heater_min_on_ff   <= RST_MIN_ON;
         heater_min_off_ff  <= RST_MIN_OFF;
         wash_ms_ff         <= RST_WASH_MS;
         wait_ms_ff         <= RST_WAIT_MS;
         rinse_ms_ff        <= RST_RINSE_MS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_READY_TEMP: ready_temp_ff      <= csr_wdata[LVL_W-1:0];
            CSR_HEAT_SETPT: heat_setpoint_ff   <= csr_wdata[LVL_W-1:0];
            CSR_HEAT_HYST:  heat_hysteresis_ff <= csr_wdata[HYST_W-1:0];
            CSR_MIN_ON:     heater_min_on_ff   <= csr_wdata[DUR_W-1:0];
            CSR_MIN_OFF:    heater_min_off_ff  <= csr_wdata[DUR_W-1:0];
            CSR_WASH_MS:    wash_ms_ff         <= csr_wdata[DUR_W-1:0];
            CSR_WAIT_MS:    wait_ms_ff         <= csr_wdata[DUR_W-1:0];
            CSR_RINSE_MS:   rinse_ms_ff        <= csr_wdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic        s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic        s0_ready, s1_ready, s2_ready;
   logic        s0_go, s1_go;
   wcs_req_type s0_data_ff;

   assign s2_ready       = !s2_valid_ff || rsp_chan.ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign s0_ready       = !s0_valid_ff || s1_ready;
   assign s0_go          = s0_valid_ff && s1_ready;
   assign s1_go          = s1_valid_ff && s2_ready;
   assign req_chan.ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) s0_valid_ff <= req_chan.valid;
         if (s1_ready) s1_valid_ff <= s0_valid_ff;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_chan.valid) begin
         s0_data_ff <= req_chan.data;
      end
   end

   // sequencer and heater state
   mode_type          mode_ff, mode_in;
   logic [TIME_W-1:0] step_start_ff, step_start_in;
   logic              ready_flag_ff, ready_flag_in;
   logic              heater_ff, heater_in;
   logic [TIME_W-1:0] heater_change_ff, heater_change_in;
   logic              first_free_ff, first_free_in;

   mode_type           mode_pwr;
   logic [TIME_W-1:0]  start_pwr;
   logic [TIME_W-1:0]  elapsed;
   logic [TIME_W-1:0]  step_el;
   logic [TIME_W-1:0]  heat_el;
   logic               tanks_full;
   logic               seq_moved;
   logic signed [CMP_W-1:0] temp_x, ready_lvl, ready_low, setpt_x, restart_x;
   logic               safe, want, cut;
   logic [DUR_W-1:0]   min_ms;
   logic [DUR_W-1:0]   step_total;
   logic               rem_hit;
   logic [DUR_W-1:0]   rem_diff;
   logic [RND_W-1:0]   rem_round;

   assign temp_x    = {{(CMP_W-TEMP_W){s0_data_ff.temperature[TEMP_W-1]}},
                       s0_data_ff.temperature};
   assign ready_lvl = {{(CMP_W-LVL_W){1'b0}}, ready_temp_ff};
   assign ready_low = ready_lvl - CMP_W'(READY_HYST_DECI);
   assign setpt_x   = {{(CMP_W-LVL_W){1'b0}}, heat_setpoint_ff};
   assign restart_x = setpt_x - {{(CMP_W-HYST_W){1'b0}}, heat_hysteresis_ff};

   assign tanks_full = s0_data_ff.tank_full && s0_data_ff.boiler_full;

   always_comb begin
      // power press first: standby toggles with fill, anything else drops to standby
      mode_pwr  = mode_ff;
      start_pwr = step_start_ff;
      if (s0_data_ff.power_pressed) begin
         mode_pwr  = (mode_ff == MODE_STANDBY) ? MODE_FILL : MODE_STANDBY;
         start_pwr = s0_data_ff.now_ms;
      end
      elapsed = s0_data_ff.now_ms - start_pwr;

      if (!s0_data_ff.temp_valid) begin
         ready_flag_in = 1'b0;
      end else if (ready_flag_ff) begin
         ready_flag_in = !(temp_x < ready_low);
      end else begin
         ready_flag_in = (temp_x >= ready_lvl);
      end

      mode_in   = mode_pwr;
      seq_moved = 1'b0;
      unique case (mode_pwr)
         MODE_STANDBY: ;
         MODE_FILL: begin
            if (tanks_full) begin
               mode_in = MODE_HEAT; seq_moved = 1'b1;
            end
         end
         MODE_HEAT: begin
            if (ready_flag_in) begin
               mode_in = MODE_READY; seq_moved = 1'b1;
            end
         end
         MODE_READY: begin
            if (!ready_flag_in) begin
               mode_in = MODE_HEAT; seq_moved = 1'b1;
            end else if (s0_data_ff.door_closed && tanks_full) begin
               mode_in = MODE_WASH; seq_moved = 1'b1;
            end
         end
         MODE_WASH: begin
            if (!s0_data_ff.door_closed) begin
               mode_in = MODE_READY; seq_moved = 1'b1;
            end else if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, wash_ms_ff}) begin
               mode_in = MODE_WAIT; seq_moved = 1'b1;
            end
         end
         MODE_WAIT: begin
            if (!s0_data_ff.door_closed) begin
               mode_in = MODE_READY; seq_moved = 1'b1;
            end else if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, wait_ms_ff}) begin
               mode_in = MODE_RINSE; seq_moved = 1'b1;
            end
         end
         MODE_RINSE: begin
            if (!s0_data_ff.door_closed) begin
               mode_in = MODE_READY; seq_moved = 1'b1;
            end else if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, rinse_ms_ff}) begin
               mode_in = MODE_FINISH; seq_moved = 1'b1;
            end
         end
         MODE_FINISH: begin
            if (!s0_data_ff.door_closed) begin
               mode_in = MODE_READY; seq_moved = 1'b1;
            end
         end
         default: ;
      endcase
      step_start_in = seq_moved ? s0_data_ff.now_ms : start_pwr;

      // heater: safety cut bypasses the min on time
      safe = (mode_in != MODE_STANDBY) && (mode_in != MODE_FILL)
             && s0_data_ff.boiler_full && s0_data_ff.temp_valid;
      if (!safe) begin
         want = 1'b0;
      end else if (heater_ff) begin
         want = (temp_x < setpt_x);
      end else begin
         want = (temp_x < restart_x);
      end
      cut     = !want && !safe;
      min_ms  = heater_ff ? heater_min_on_ff : heater_min_off_ff;
      heat_el = s0_data_ff.now_ms - heater_change_ff;

      heater_in        = heater_ff;
      heater_change_in = heater_change_ff;
      first_free_in    = first_free_ff;
      if ((want != heater_ff) &&
          (cut || first_free_ff || heat_el >= {{(TIME_W-DUR_W){1'b0}}, min_ms})) begin
         heater_in        = want;
         heater_change_in = s0_data_ff.now_ms;
         first_free_in    = 1'b0;
      end

      case (mode_in)
         MODE_WASH:  step_total = wash_ms_ff;
         MODE_WAIT:  step_total = wait_ms_ff;
         MODE_RINSE: step_total = rinse_ms_ff;
         default:    step_total = '0;
      endcase
      step_el   = seq_moved ? '0 : elapsed;
      rem_hit   = (step_total != '0) && (step_el < {{(TIME_W-DUR_W){1'b0}}, step_total});
      rem_diff  = step_total - step_el[DUR_W-1:0];
      rem_round = {1'b0, rem_diff} + {{(RND_W-10){1'b0}}, ROUND_UP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_STANDBY;
         step_start_ff    <= '0;
         ready_flag_ff    <= 1'b0;
         heater_ff        <= 1'b0;
         heater_change_ff <= '0;
         first_free_ff    <= 1'b1;
      end else if (s0_go) begin
         mode_ff          <= mode_in;
         step_start_ff    <= step_start_in;
         ready_flag_ff    <= ready_flag_in;
         heater_ff        <= heater_in;
         heater_change_ff <= heater_change_in;
         first_free_ff    <= first_free_in;
      end
   end

   // stage 1: decoded outputs plus the rounded dividend
   wcs_rsp_type      s1_rsp_ff;
   logic             s1_rem_hit_ff;
   logic [RND_W-1:0] s1_round_ff;

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_rsp_ff.tank_valve    <= (mode_in != MODE_STANDBY) && !s0_data_ff.tank_full;
         s1_rsp_ff.boiler_valve  <= (mode_in != MODE_STANDBY) && !s0_data_ff.boiler_full;
         s1_rsp_ff.heater        <= heater_in;
         s1_rsp_ff.wash_pump     <= (mode_in == MODE_WASH);
         s1_rsp_ff.rinse_pump    <= (mode_in == MODE_RINSE);
         s1_rsp_ff.mode          <= mode_in;
         s1_rsp_ff.water_ready   <= ready_flag_in;
         s1_rsp_ff.remaining_sec <= '0;
         s1_rem_hit_ff           <= rem_hit;
         s1_round_ff             <= rem_round;
      end
   end

   // stage 2: divide by 1000 as divide by 8, then reciprocal multiply for 125
   logic [DIV_M_W-1:0] div_m;
   logic [PROD_W-1:0]  div_prod;
   logic [SEC_W-1:0]   rem_sec;

   assign div_m    = s1_round_ff[RND_W-1:3];
   assign div_prod = {{RECIP_W{1'b0}}, div_m} * {{DIV_M_W{1'b0}}, RECIP_125};
   assign rem_sec  = s1_rem_hit_ff ? div_prod[RECIP_SH+SEC_W-1:RECIP_SH] : '0;

   wcs_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in               = s1_rsp_ff;
      rsp_data_in.remaining_sec = rem_sec;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = s2_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
